FILE: rtl/gtms_pkg.sv
// Shared types and constants for the gated trimmed-mean sampler.
// Used by gated_trimmed_mean_sampler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gtms_pkg;

  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 10;
  localparam int ThreshW   = 10;
  localparam int NeedW     = 6;
  localparam int CountW    = 10;
  localparam int ShiftW    = 3;
  localparam int ValueW    = 16;
  localparam int StatusW   = 2;
  localparam int OutDataW  = 24;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MISSES    = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_THRESHOLD      = 3'd0,
    REG_SAMPLES_NEEDED = 3'd1,
    REG_MISS_LIMIT     = 3'd2,
    REG_ATTEMPT_LIMIT  = 3'd3,
    REG_RESULT_SHIFT   = 3'd4
  } cfg_reg_t;

  localparam logic [ThreshW-1:0] ThresholdRst    = 10'd3;
  localparam logic [NeedW-1:0]   SamplesNeedRst  = 6'd21;
  localparam logic [CountW-1:0]  MissLimitRst    = 10'd900;
  localparam logic [CountW-1:0]  AttemptLimitRst = 10'd1000;
  localparam logic [ShiftW-1:0]  ResultShiftRst  = 3'd2;
  localparam logic [CountW-1:0]  CountMax        = 10'd1023;

endpackage

`default_nettype wire

FILE: rtl/gated_trimmed_mean_sampler.sv
// Gated trimmed-mean sampler: gates attempts on trigger samples, tracks min/max/sum
// and emits (sum - min - max) >> shift or a failure status. Depends on gtms_pkg.
//
// Usage:
//   Input words (in_*) carry one attempt: trigger before, data sample, trigger after.
//   Result words (out_*) carry the value and a status (ok, too many misses,
//   attempts exhausted); an attempt yields zero or one result word.
//   cfg_we/cfg_addr/cfg_wdata write the five control registers; the user must write
//   them only while idle, since the block has no check of its own for this.
//   An accepted word enters the input register; its result, if any, goes to the
//   result register. Throughput: one attempt per cycle unless the output stalls;
//   all gating, min/max, sum and trim logic is combinational between the two registers.
//   Stall: while a result word is held unaccepted, the input register does not
//   advance and in_tready drops once it is full; nothing is lost or repeated.
//   Reset (rst_n low, synchronous): registers return to their defaults
//   (threshold 3, 21 samples, miss limit 900, attempt limit 1000, shift 2),
//   the measurement clears and both channels empty.
//   Every result, good or failed, clears the measurement state.
`timescale 1ns / 1ps
`default_nettype none

module gated_trimmed_mean_sampler #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // trigger_before, data_sample, trigger_after (SAMPLE_BITS each), zero pad
  input  wire  [((3*SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // value [15:0], status [17:16], zero pad
  output logic [gtms_pkg::OutDataW-1:0]       out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire                                 cfg_we,
  input  wire  [gtms_pkg::CfgAddrW-1:0]       cfg_addr,
  input  wire  [gtms_pkg::CfgDataW-1:0]       cfg_wdata
);

  import gtms_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = (SB > ThreshW) ? SB : ThreshW;
  localparam int SUMW = SB + NeedW;
  localparam int VW   = (SUMW > ValueW) ? SUMW : ValueW;
  localparam int INW  = ((3*SB+7)/8)*8;
  localparam logic [SB-1:0] SampleMask = {SB{1'b1}};

  // configuration
  logic [ThreshW-1:0] threshold_r;
  logic [NeedW-1:0]   samples_needed_r;
  logic [CountW-1:0]  miss_limit_r;
  logic [CountW-1:0]  attempt_limit_r;
  logic [ShiftW-1:0]  result_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r      <= ThresholdRst;
      samples_needed_r <= SamplesNeedRst;
      miss_limit_r     <= MissLimitRst;
      attempt_limit_r  <= AttemptLimitRst;
      result_shift_r   <= ResultShiftRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESHOLD:      threshold_r      <= cfg_wdata[ThreshW-1:0];
        REG_SAMPLES_NEEDED: samples_needed_r <= cfg_wdata[NeedW-1:0];
        REG_MISS_LIMIT:     miss_limit_r     <= cfg_wdata[CountW-1:0];
        REG_ATTEMPT_LIMIT:  attempt_limit_r  <= cfg_wdata[CountW-1:0];
        REG_RESULT_SHIFT:   result_shift_r   <= cfg_wdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic          in_valid_r;
  logic [SB-1:0] trig_a_r, data_r, trig_b_r;
  logic          advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      trig_a_r <= in_tdata[SB-1:0];
      data_r   <= in_tdata[2*SB-1:SB];
      trig_b_r <= in_tdata[3*SB-1:2*SB];
    end
  end

  // measurement state
  logic [CountW-1:0] attempt_r, miss_r;
  logic [NeedW-1:0]  accepted_r;
  logic [SB-1:0]     min_r, max_r;
  logic [SUMW-1:0]   sum_r;

  logic [CountW-1:0] attempt_nxt, miss_nxt;
  logic [NeedW-1:0]  accepted_nxt, need;
  logic [SB-1:0]     min_nxt, max_nxt;
  logic [SUMW-1:0]   sum_nxt;
  logic [CW-1:0]     thr_x, trig_a_x, trig_b_x;
  logic              is_miss, take, done, exhaust, emit;
  logic [SB:0]       drop;
  logic [VW-1:0]     trimmed, shifted;
  logic [ValueW-1:0] value_res;
  status_t           status_res;

  always_comb begin
    thr_x    = CW'(threshold_r);
    trig_a_x = CW'(trig_a_r);
    trig_b_x = CW'(trig_b_r);
    need     = (samples_needed_r == '0) ? NeedW'(1) : samples_needed_r;

    attempt_nxt  = (attempt_r == CountMax) ? attempt_r : attempt_r + CountW'(1);
    is_miss      = trig_a_x >= thr_x;
    take         = !is_miss && (trig_b_x <= thr_x);
    miss_nxt     = (is_miss && miss_r != CountMax) ? miss_r + CountW'(1) : miss_r;
    accepted_nxt = take ? accepted_r + NeedW'(1) : accepted_r;
    min_nxt      = (take && data_r < min_r) ? data_r : min_r;
    max_nxt      = (take && data_r > max_r) ? data_r : max_r;
    sum_nxt      = take ? sum_r + SUMW'(data_r) : sum_r;
    done         = take && (accepted_nxt >= need);
    exhaust      = attempt_nxt >= attempt_limit_r;

    drop    = (SB+1)'(min_nxt) + (SB+1)'(max_nxt);
    trimmed = (VW'(sum_nxt) > VW'(drop)) ? VW'(sum_nxt) - VW'(drop) : '0;
    shifted = trimmed >> result_shift_r;

    emit       = 1'b0;
    value_res  = '0;
    status_res = STATUS_OK;
    priority if (is_miss && miss_nxt > miss_limit_r) begin
      emit       = 1'b1;
      status_res = STATUS_MISSES;
    end else if (done) begin
      emit      = 1'b1;
      value_res = (|(shifted >> ValueW)) ? {ValueW{1'b1}} : shifted[ValueW-1:0];
    end else if (exhaust) begin
      emit       = 1'b1;
      status_res = STATUS_EXHAUSTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (advance && emit)) begin
      attempt_r  <= '0;
      miss_r     <= '0;
      accepted_r <= '0;
      min_r      <= SampleMask;
      max_r      <= '0;
      sum_r      <= '0;
    end else if (advance) begin
      attempt_r  <= attempt_nxt;
      miss_r     <= miss_nxt;
      accepted_r <= accepted_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      sum_r      <= sum_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (!out_tvalid || out_tready) begin
      out_tvalid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_tdata <= {{(OutDataW-ValueW-StatusW){1'b0}}, status_res, value_res};
    end
  end

  logic unused_pad;
  assign unused_pad = ^{1'b0, in_tdata[INW-1:3*SB-1]};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for gated_trimmed_mean_sampler: a directed table of attempts,
// then random attempt streams; results checked against fixed values or an in-bench model.
// Depends on gtms_pkg and the gated_trimmed_mean_sampler RTL.
`timescale 1ns / 1ps

module tb_top;
  import gtms_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    status_t     status;
  } meas_t;

  typedef struct packed {
    logic [9:0] trig_pre;
    logic [9:0] sample;
    logic [9:0] trig_post;
    bit         fixed;
    meas_t      fixed_res;
  } word_t;

  typedef struct packed {
    bit         is_cfg;
    cfg_reg_t   reg_idx;
    logic [9:0] reg_val;
    word_t      w;
  } plan_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [31:0]         in_tdata = '0;     // trigger_before, data_sample, trigger_after, pad
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OutDataW-1:0] out_tdata;         // value [15:0], status [17:16], pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = REG_THRESHOLD;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned send_gap_pct = 9;
  int unsigned recv_gap_pct = 68;
  int          hold_left = 0;
  int          n_fail = 0;

  // model copy of the registers and the measurement
  int unsigned gate_level  = ThresholdRst;
  int unsigned need_count  = SamplesNeedRst;
  int unsigned miss_cap    = MissLimitRst;
  int unsigned attempt_cap = AttemptLimitRst;
  int unsigned shift_amt   = ResultShiftRst;
  int unsigned attempts = 0, misses = 0, accepted = 0;
  int unsigned lo = 1023, hi = 0, total = 0;

  word_t offered[$];
  meas_t pending_results[$];
  plan_t plan[$];

  gated_trimmed_mean_sampler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic void restart_measurement();
    attempts = 0;
    misses   = 0;
    accepted = 0;
    lo       = 1023;
    hi       = 0;
    total    = 0;
  endfunction

  function automatic bit run_attempt(input int unsigned tp, input int unsigned s,
                                     input int unsigned tq, output meas_t res);
    int unsigned needed;
    int unsigned drop;
    int unsigned trimmed;
    needed = (need_count == 0) ? 1 : need_count;
    res.value  = '0;
    res.status = STATUS_OK;
    if (attempts < 1023) attempts++;
    if (tp >= gate_level) begin
      if (misses < 1023) misses++;
      if (misses > miss_cap) begin
        res.status = STATUS_MISSES;
        restart_measurement();
        return 1'b1;
      end
    end else if (tq <= gate_level) begin
      accepted = (accepted + 1) & 63;
      if (s < lo) lo = s;
      if (s > hi) hi = s;
      total += s;
      if (accepted >= needed) begin
        drop    = lo + hi;
        trimmed = (total > drop) ? total - drop : 0;
        trimmed = trimmed >> shift_amt;
        if (trimmed > 65535) trimmed = 65535;
        res.value = 16'(trimmed);
        restart_measurement();
        return 1'b1;
      end
    end
    if (attempts >= attempt_cap) begin
      res.status = STATUS_EXHAUSTED;
      restart_measurement();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    meas_t      want;
    meas_t      calc;
    word_t      w;
    logic [1:0] got_status;
    bit         hit;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[17:16];
        if (pending_results.size() == 0) begin
          $error("unexpected result word: value %0d status %0d", out_tdata[15:0], got_status);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[15:0] !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_tdata[15:0]);
            n_fail++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w   = offered.pop_front();
        hit = run_attempt(w.trig_pre, w.sample, w.trig_post, calc);
        if (w.fixed) pending_results.push_back(w.fixed_res);
        else if (hit) pending_results.push_back(calc);
      end
    end
  end

  // receiver: random back-pressure plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  task automatic send(input word_t w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    offered.push_back(w);
    in_tdata  <= {2'b00, w.trig_post, w.sample, w.trig_pre};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while ((pending_results.size() != 0 || offered.size() != 0) && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 5000) begin
      $error("result words still outstanding: %0d", pending_results.size());
      n_fail++;
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD:      gate_level  = val;
      REG_SAMPLES_NEEDED: need_count  = val[5:0];
      REG_MISS_LIMIT:     miss_cap    = val;
      REG_ATTEMPT_LIMIT:  attempt_cap = val;
      REG_RESULT_SHIFT:   shift_amt   = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic void add_cfg(input cfg_reg_t idx, input int unsigned val);
    plan_t p;
    p = '0;
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = 10'(val);
    plan.push_back(p);
  endfunction

  function automatic void add_word(input int unsigned tp, input int unsigned s,
                                   input int unsigned tq, input bit fixed = 1'b0,
                                   input int unsigned v = 0,
                                   input status_t st = STATUS_OK);
    plan_t p;
    p = '0;
    p.w.trig_pre         = 10'(tp);
    p.w.sample           = 10'(s);
    p.w.trig_post        = 10'(tq);
    p.w.fixed            = fixed;
    p.w.fixed_res.value  = 16'(v);
    p.w.fixed_res.status = st;
    plan.push_back(p);
  endfunction

  function automatic word_t rand_word(input int unsigned t);
    word_t       w;
    int unsigned pick;
    w    = '0;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) w.sample = $urandom_range(0, 1) ? 10'h3ff : 10'h000;
    else w.sample = 10'($urandom_range(0, 1023));
    if (pick < 10 || t == 0) w.trig_pre = 10'($urandom_range(t, 1023));
    else w.trig_pre = 10'($urandom_range(0, t - 1));
    if (pick >= 90 && t < 1023) w.trig_post = 10'($urandom_range(t + 1, 1023));
    else w.trig_post = 10'($urandom_range(0, t));
    return w;
  endfunction

  initial begin
    plan_t       p;
    int unsigned thr, need, mlim, alim, shamt;

    // miss over a zero limit, then a three-sample trim at full threshold
    add_cfg(REG_THRESHOLD, 1023);
    add_cfg(REG_SAMPLES_NEEDED, 3);
    add_cfg(REG_MISS_LIMIT, 0);
    add_cfg(REG_ATTEMPT_LIMIT, 1023);
    add_cfg(REG_RESULT_SHIFT, 0);
    add_word(1023, 0, 0, 1'b1, 0, STATUS_MISSES);
    add_word(0, 1023, 1023);
    add_word(0, 0, 0);
    add_word(1022, 512, 1023, 1'b1, 512, STATUS_OK);
    // zero threshold: every attempt a miss; zero attempt limit acts as one
    add_cfg(REG_THRESHOLD, 0);
    add_cfg(REG_MISS_LIMIT, 1023);
    add_cfg(REG_ATTEMPT_LIMIT, 0);
    add_word(0, 1023, 0, 1'b1, 0, STATUS_EXHAUSTED);
    add_word(1023, 1023, 1023, 1'b1, 0, STATUS_EXHAUSTED);
    // zero samples needed acts as one; completion beats exhaustion
    add_cfg(REG_THRESHOLD, 512);
    add_cfg(REG_SAMPLES_NEEDED, 0);
    add_cfg(REG_ATTEMPT_LIMIT, 1);
    add_cfg(REG_RESULT_SHIFT, 7);
    add_word(0, 1023, 512, 1'b1, 0, STATUS_OK);
    add_word(511, 5, 513, 1'b1, 0, STATUS_EXHAUSTED);
    add_word(512, 0, 0, 1'b1, 0, STATUS_EXHAUSTED);
    // miss crossing the limit beats exhaustion
    add_cfg(REG_MISS_LIMIT, 2);
    add_cfg(REG_ATTEMPT_LIMIT, 3);
    add_cfg(REG_SAMPLES_NEEDED, 63);
    add_word(512, 100, 0);
    add_word(1023, 200, 0);
    add_word(600, 7, 7, 1'b1, 0, STATUS_MISSES);
    // two samples trim to zero
    add_cfg(REG_THRESHOLD, 1023);
    add_cfg(REG_SAMPLES_NEEDED, 2);
    add_cfg(REG_ATTEMPT_LIMIT, 1023);
    add_cfg(REG_MISS_LIMIT, 900);
    add_cfg(REG_RESULT_SHIFT, 0);
    add_word(0, 1023, 0);
    add_word(0, 1023, 0, 1'b1, 0, STATUS_OK);
    add_cfg(REG_THRESHOLD, 100);
    add_cfg(REG_SAMPLES_NEEDED, 3);
    add_word(99, 300, 100);
    add_word(100, 5, 5);
    add_word(50, 200, 101);
    add_word(0, 700, 0);
    add_word(0, 1, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    foreach (plan[i]) begin
      p = plan[i];
      if (p.is_cfg) begin
        settle();
        write_reg(p.reg_idx, p.reg_val);
      end else begin
        send(p.w);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_gap_pct = (ph < 2) ? 9 : (ph < 4) ? 68 : 0;
      recv_gap_pct = (ph < 2) ? 68 : (ph < 4) ? 9 : 0;
      thr   = (ph == 0) ? 1023 : $urandom_range(1, 1022);
      need  = (ph == 3) ? 63 : $urandom_range(3, 10);
      mlim  = (ph == 3) ? 1023 : $urandom_range(3, 30);
      alim  = (ph == 3) ? 1023 : $urandom_range(15, 120);
      shamt = (ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7);
      write_reg(REG_THRESHOLD, 10'(thr));
      write_reg(REG_SAMPLES_NEEDED, 10'(need));
      write_reg(REG_MISS_LIMIT, 10'(mlim));
      write_reg(REG_ATTEMPT_LIMIT, 10'(alim));
      write_reg(REG_RESULT_SHIFT, 10'(shamt));
      if (ph == 4) hold_left = 300;
      repeat (90) send(rand_word(gate_level));
    end

    settle();
    repeat (6) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gtms_pkg.sv
rtl/gated_trimmed_mean_sampler.sv
bench/tb_top.sv
